// File: rtl/odfs_pkg.sv
// shared constants, types and codes of the odd-length fir smoother
// no dependencies; imported by every module of the block
package odfs_pkg;

    localparam int MAX_HALF_WIDTH = 8;
    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_BITS      = 18;
    localparam int NTAPS          = 2 * MAX_HALF_WIDTH + 1;
    localparam int COEF_FRAC      = COEF_BITS - 4;
    localparam int PROD_W         = SAMPLE_BITS + COEF_BITS;
    localparam int CNT_W          = $clog2(NTAPS);
    localparam int ACC_W          = PROD_W + CNT_W + 1;
    localparam int HW_W           = 4;
    localparam int IDX_W          = 5;
    localparam int SEEN_W         = 5;
    localparam int SEEN_MAX       = 2 ** SEEN_W - 1;
    localparam int CMP_W          = SEEN_W + 2;
    localparam int COPY_W         = $clog2(NTAPS + 1);
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 4;

    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(longint'(1) << (COEF_FRAC - 1));
    localparam logic signed [ACC_W-1:0] SMP_HI   = ACC_W'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SMP_LO   = ACC_W'(-(longint'(1) << (SAMPLE_BITS - 1)));

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTEND     = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ROT,
        ST_SUM,
        ST_RND,
        ST_EMIT,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic fill;
        logic shift;
        logic rotate;
        logic capture;
        logic drain;
        logic tap_we;
    } t_cell_ctl;

endpackage

// File: rtl/odfs_cell.sv
// one cell of the smoothing chain: a window sample, a kernel tap and a product
// depends on odfs_pkg
module odfs_cell (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  odfs_pkg::t_cell_ctl                    i_ctl,
    input  logic                                   i_active,
    input  logic signed [odfs_pkg::SAMPLE_BITS-1:0] i_fill,
    input  logic signed [odfs_pkg::SAMPLE_BITS-1:0] i_win_in,
    input  logic signed [odfs_pkg::COEF_BITS-1:0]   i_coef,
    input  logic signed [odfs_pkg::PROD_W-1:0]      i_prod_in,
    output logic signed [odfs_pkg::SAMPLE_BITS-1:0] o_win,
    output logic signed [odfs_pkg::PROD_W-1:0]      o_prod
);
    import odfs_pkg::*;

    logic signed [SAMPLE_BITS-1:0] r_win;
    logic signed [COEF_BITS-1:0]   r_tap;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [PROD_W-1:0]      w_mul;

    assign w_mul  = r_win * r_tap;
    assign o_win  = r_win;
    assign o_prod = r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap <= '0;
        end else if (i_ctl.tap_we) begin
            r_tap <= i_coef;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.fill) begin
            r_win <= i_fill;
        end else if (i_ctl.shift || i_ctl.rotate) begin
            r_win <= i_win_in;
        end
        // taps beyond the current kernel length contribute nothing
        if (i_ctl.capture) begin
            r_prod <= i_active ? w_mul : '0;
        end else if (i_ctl.drain) begin
            r_prod <= i_prod_in;
        end
    end

endmodule

// File: rtl/odfs_chain.sv
// row of smoothing cells: window shift/rotate ring and product drain line
// depends on odfs_pkg and odfs_cell
module odfs_chain (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  odfs_pkg::t_cell_ctl                    i_ctl,
    input  logic [odfs_pkg::HW_W-1:0]              i_hw,
    input  logic signed [odfs_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic [odfs_pkg::IDX_W-1:0]             i_tap_index,
    input  logic signed [odfs_pkg::COEF_BITS-1:0]   i_coef,
    output logic signed [odfs_pkg::PROD_W-1:0]      o_prod_head
);
    import odfs_pkg::*;

    logic signed [SAMPLE_BITS-1:0] w_win  [NTAPS];
    logic signed [PROD_W-1:0]      w_prod [NTAPS];

    assign o_prod_head = w_prod[0];

    for (genvar k = 0; k < NTAPS; k++) begin : g_cell
        t_cell_ctl                     w_ctl;
        logic                          w_active;
        logic signed [SAMPLE_BITS-1:0] w_win_in;
        logic signed [PROD_W-1:0]      w_prod_in;

        always_comb begin
            w_ctl        = i_ctl;
            w_ctl.tap_we = i_ctl.tap_we && (i_tap_index == IDX_W'(k));
        end

        assign w_active = (k <= 2 * int'(i_hw));

        // newest sample enters at the top end; a rotation wraps the oldest round
        if (k == NTAPS - 1) begin : g_top
            assign w_win_in  = i_ctl.rotate ? w_win[0] : i_sample;
            assign w_prod_in = '0;
        end else begin : g_mid
            assign w_win_in  = w_win[k+1];
            assign w_prod_in = w_prod[k+1];
        end

        odfs_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_active  (w_active),
            .i_fill    (i_sample),
            .i_win_in  (w_win_in),
            .i_coef    (i_coef),
            .i_prod_in (w_prod_in),
            .o_win     (w_win[k]),
            .o_prod    (w_prod[k])
        );
    end

endmodule

// File: rtl/odd_fir_smoother_with_borders.sv
// top level of the odd-length fir smoother with border handling
// depends on odfs_pkg and odfs_chain (which holds the odfs_cell row)
//
// input channel (i_valid/o_ready): one transaction is a sample (opcode 0) or a
// kernel coefficient write (opcode 1, slot tap_index, out-of-range slots ignored).
// output channel (o_valid/i_ready): smoothed results in signal order, last_out on
// the final result of a signal, too_short on the single result of a signal that
// is shorter than the kernel when border extension is off.
// config channel (i_cfg_valid/o_cfg_ready, always ready): index 0 half_width,
// index 1 extend_borders; write only while the block is idle.
// a coefficient write is taken straight into its tap. a sample that yields a result
// passes through a decision step, a full turn of the window ring so the cells line
// up with the kernel, a drain of the products through one accumulator, a rounding
// step and the load of the output register. repeated copies follow one per cycle
// while the receiver takes them; in extend mode each extra border result passes
// through a push step and all of these steps again.
// a new transaction is taken once the last result of the previous one sits in
// the output register; while the receiver stalls the block waits on that register.
// reset clears the kernel, the sample count and the output valid flag, and restores
// half_width 2 with border extension on.
module odd_fir_smoother_with_borders (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic                                   i_opcode,
    input  logic signed [odfs_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic [odfs_pkg::IDX_W-1:0]             i_tap_index,
    input  logic signed [odfs_pkg::COEF_BITS-1:0]   i_coef,
    input  logic                                   i_last,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [odfs_pkg::SAMPLE_BITS-1:0] o_smoothed,
    output logic                                   o_last_out,
    output logic                                   o_too_short,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [odfs_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [odfs_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import odfs_pkg::*;

    t_state                        r_state, n_state;
    logic [HW_W-1:0]               r_hw_cfg;
    logic                          r_ext_cfg;
    logic [SEEN_W-1:0]             r_seen, n_seen;
    logic                          r_ovalid, n_ovalid;
    logic [CNT_W-1:0]              r_cnt, n_cnt;
    logic [HW_W-1:0]               r_t, n_t;
    logic [COPY_W-1:0]             r_copies, n_copies;
    logic signed [SAMPLE_BITS-1:0] r_s, n_s;
    logic                          r_last, n_last;
    logic [HW_W-1:0]               r_hw, n_hw;
    logic                          r_ext, n_ext;
    logic [SEEN_W-1:0]             r_n, n_n;
    logic [CNT_W-1:0]              r_base, n_base;
    logic signed [ACC_W-1:0]       r_acc, n_acc;
    logic signed [SAMPLE_BITS-1:0] r_v, n_v;
    logic                          r_short, n_short;
    logic signed [SAMPLE_BITS-1:0] r_smoothed, n_smoothed;
    logic                          r_last_out, n_last_out;
    logic                          r_too_short, n_too_short;

    t_cell_ctl                     w_ctl;
    logic signed [PROD_W-1:0]      w_prod_head;
    logic signed [SAMPLE_BITS-1:0] w_chain_sample;
    logic [HW_W-1:0]               w_hw_eff;
    logic [SEEN_W-1:0]             w_n;
    logic [CMP_W-1:0]              w_nt, w_hw1, w_taps;
    logic [COPY_W-1:0]             w_copies_full;
    logic signed [ACC_W-1:0]       w_rnd, w_shr;
    logic                          w_out_free;

    assign o_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_ovalid;
    assign o_smoothed  = r_smoothed;
    assign o_last_out  = r_last_out;
    assign o_too_short = r_too_short;

    assign w_chain_sample = (r_state == ST_PUSH) ? r_s : i_sample;
    assign w_out_free     = !r_ovalid || i_ready;

    always_comb begin
        if (r_hw_cfg == '0) begin
            w_hw_eff = HW_W'(1);
        end else if (r_hw_cfg > HW_W'(MAX_HALF_WIDTH)) begin
            w_hw_eff = HW_W'(MAX_HALF_WIDTH);
        end else begin
            w_hw_eff = r_hw_cfg;
        end
    end

    assign w_n    = (r_seen < SEEN_W'(SEEN_MAX)) ? r_seen + SEEN_W'(1) : SEEN_W'(SEEN_MAX);
    assign w_nt   = CMP_W'(r_n) + CMP_W'(r_t);
    assign w_hw1  = CMP_W'(r_hw) + CMP_W'(1);
    assign w_taps = (CMP_W'(r_hw) << 1) + CMP_W'(1);

    // left-edge copies on the first full window, right-edge copies on last
    assign w_copies_full = ((CMP_W'(r_n) == w_taps) ? COPY_W'(r_hw) + COPY_W'(1) : COPY_W'(1))
                         + (r_last ? COPY_W'(r_hw) : COPY_W'(0));

    assign w_rnd = r_acc + RND_HALF;
    assign w_shr = w_rnd >>> COEF_FRAC;

    odfs_chain u_chain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_hw        (r_hw),
        .i_sample    (w_chain_sample),
        .i_tap_index (i_tap_index),
        .i_coef      (i_coef),
        .o_prod_head (w_prod_head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_hw_cfg  <= HW_W'(2);
            r_ext_cfg <= 1'b1;
            r_seen    <= '0;
            r_ovalid  <= 1'b0;
            r_cnt     <= '0;
            r_t       <= '0;
            r_copies  <= '0;
        end else begin
            r_state  <= n_state;
            r_seen   <= n_seen;
            r_ovalid <= n_ovalid;
            r_cnt    <= n_cnt;
            r_t      <= n_t;
            r_copies <= n_copies;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_HALF_WIDTH: r_hw_cfg  <= i_cfg_data[HW_W-1:0];
                    CFG_EXTEND:     r_ext_cfg <= i_cfg_data[0];
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s         <= n_s;
        r_last      <= n_last;
        r_hw        <= n_hw;
        r_ext       <= n_ext;
        r_n         <= n_n;
        r_base      <= n_base;
        r_acc       <= n_acc;
        r_v         <= n_v;
        r_short     <= n_short;
        r_smoothed  <= n_smoothed;
        r_last_out  <= n_last_out;
        r_too_short <= n_too_short;
    end

    always_comb begin
        n_state     = r_state;
        n_seen      = r_seen;
        n_ovalid    = r_ovalid;
        n_cnt       = r_cnt;
        n_t         = r_t;
        n_copies    = r_copies;
        n_s         = r_s;
        n_last      = r_last;
        n_hw        = r_hw;
        n_ext       = r_ext;
        n_n         = r_n;
        n_base      = r_base;
        n_acc       = r_acc;
        n_v         = r_v;
        n_short     = r_short;
        n_smoothed  = r_smoothed;
        n_last_out  = r_last_out;
        n_too_short = r_too_short;
        w_ctl       = '0;

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_opcode == OP_COEF) begin
                        w_ctl.tap_we = 1'b1;
                    end else begin
                        // first sample of a signal fills the whole window
                        w_ctl.fill  = (r_seen == '0);
                        w_ctl.shift = (r_seen != '0);
                        n_s     = i_sample;
                        n_last  = i_last;
                        n_hw    = w_hw_eff;
                        n_ext   = r_ext_cfg;
                        n_n     = w_n;
                        n_t     = '0;
                        n_base  = CNT_W'(NTAPS - 1) - (CNT_W'(w_hw_eff) << 1);
                        n_seen  = i_last ? '0 : w_n;
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (r_ext) begin
                    if (w_nt >= w_hw1) begin
                        n_copies = COPY_W'(1);
                        n_short  = 1'b0;
                        n_cnt    = '0;
                        n_state  = ST_ROT;
                    end else if (r_last && (r_t < r_hw)) begin
                        n_state = ST_PUSH;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else if (CMP_W'(r_n) < w_taps) begin
                    if (r_last) begin
                        n_v      = '0;
                        n_short  = 1'b1;
                        n_copies = COPY_W'(1);
                        n_state  = ST_EMIT;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_copies = w_copies_full;
                    n_short  = 1'b0;
                    n_cnt    = '0;
                    n_state  = ST_ROT;
                end
            end
            ST_ROT: begin
                // one full turn of the ring; products are taken when aligned
                w_ctl.rotate  = 1'b1;
                w_ctl.capture = (r_cnt == r_base);
                if (r_cnt == CNT_W'(NTAPS - 1)) begin
                    n_cnt   = '0;
                    n_acc   = '0;
                    n_state = ST_SUM;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_SUM: begin
                w_ctl.drain = 1'b1;
                n_acc = r_acc + {{(ACC_W - PROD_W){w_prod_head[PROD_W-1]}}, w_prod_head};
                if (r_cnt == CNT_W'(NTAPS - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_RND;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_RND: begin
                if (w_shr > SMP_HI) begin
                    n_v = SMP_HI[SAMPLE_BITS-1:0];
                end else if (w_shr < SMP_LO) begin
                    n_v = SMP_LO[SAMPLE_BITS-1:0];
                end else begin
                    n_v = w_shr[SAMPLE_BITS-1:0];
                end
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_ovalid    = 1'b1;
                    n_smoothed  = r_v;
                    n_too_short = r_short;
                    n_last_out  = r_ext ? (r_last && (r_t == r_hw))
                                        : (r_last && (r_copies == COPY_W'(1)));
                    n_copies    = r_copies - COPY_W'(1);
                    if (r_copies == COPY_W'(1)) begin
                        if (r_ext && r_last && (r_t < r_hw)) begin
                            n_state = ST_PUSH;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            ST_PUSH: begin
                // replicate the final sample past the right edge
                w_ctl.shift = 1'b1;
                n_t     = r_t + HW_W'(1);
                n_state = ST_CHECK;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: verif/odd_fir_smoother_with_borders_tb.sv
// testbench for odd_fir_smoother_with_borders: directed and random sample streams,
// kernel loads and register settings, checked against a cycle-free smoothing predictor
// depends on odfs_pkg and the rtl of the block
module odd_fir_smoother_with_borders_tb;
    import odfs_pkg::*;

    localparam int     CYCLE_LIMIT   = 1_000_000;
    localparam int     SETTLE_CYCLES = 400;
    localparam int     PHASE_WORDS   = 20;
    localparam int     PHASES        = 6;
    localparam longint OUT_MAX       = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint OUT_MIN       = -(longint'(1) << (SAMPLE_BITS - 1));

    typedef struct packed {
        logic                   op;
        logic [SAMPLE_BITS-1:0] smp;
        logic [IDX_W-1:0]       idx;
        logic [COEF_BITS-1:0]   cf;
        logic                   lst;
    } t_stream_word;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] value;
        logic                   at_end;
        logic                   too_short;
    } t_smoothed;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_valid     = 1'b0;
    logic                          o_ready;
    logic                          i_opcode    = OP_SAMPLE;
    logic signed [SAMPLE_BITS-1:0] i_sample    = '0;
    logic [IDX_W-1:0]              i_tap_index = '0;
    logic signed [COEF_BITS-1:0]   i_coef      = '0;
    logic                          i_last      = 1'b0;
    logic                          o_valid;
    logic                          i_ready     = 1'b0;
    logic signed [SAMPLE_BITS-1:0] o_smoothed;
    logic                          o_last_out;
    logic                          o_too_short;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [CFG_IDX_W-1:0]          i_cfg_index = CFG_HALF_WIDTH;
    logic [CFG_DATA_W-1:0]         i_cfg_data  = '0;

    // predictor state, mirrors the block after reset
    logic signed [SAMPLE_BITS-1:0] win [NTAPS];
    logic signed [COEF_BITS-1:0]   kern [NTAPS];
    logic [SEEN_W-1:0]             seen_cnt        = '0;
    logic [HW_W-1:0]               cfg_half_width  = 4'd2;
    logic                          cfg_extend      = 1'b1;

    t_stream_word word_q [$];
    t_smoothed    smoothed_due [$];
    t_stream_word next_word;
    t_stream_word taken_word;
    t_smoothed    due_now;
    logic         word_taken    = 1'b0;
    int           send_idle_pct = 0;
    int           stall_pct     = 0;
    int           queued        = 0;
    int           mismatches    = 0;
    int           cycles        = 0;

    int phase_hw    [PHASES] = '{1, 8, 3, 15, 1, 5};
    int phase_ext   [PHASES] = '{1, 0, 0, 1, 0, 1};
    int phase_idle  [PHASES] = '{0, 70, 0, 21, 70, 0};
    int phase_stall [PHASES] = '{0, 0, 70, 21, 0, 70};

    odd_fir_smoother_with_borders dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_opcode    (i_opcode),
        .i_sample    (i_sample),
        .i_tap_index (i_tap_index),
        .i_coef      (i_coef),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_smoothed  (o_smoothed),
        .o_last_out  (o_last_out),
        .o_too_short (o_too_short),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        foreach (win[k]) begin
            win[k]  = '0;
            kern[k] = '0;
        end
    end

    // ---------------- predictor ----------------

    function automatic void shift_in(input logic signed [SAMPLE_BITS-1:0] s);
        int k;
        for (k = 0; k < NTAPS - 1; k++) win[k] = win[k + 1];
        win[NTAPS - 1] = s;
    endfunction

    // kernel over the youngest 2*hw+1 samples, rounded to nearest and saturated
    function automatic logic [SAMPLE_BITS-1:0] fir_value(input int hw);
        longint acc;
        int     base;
        int     k;
        acc  = 0;
        base = NTAPS - (2 * hw + 1);
        for (k = 0; k < 2 * hw + 1; k++)
            acc += longint'(kern[k]) * longint'(win[base + k]);
        acc = (acc + (longint'(1) << (COEF_FRAC - 1))) >>> COEF_FRAC;
        if (acc > OUT_MAX) acc = OUT_MAX;
        if (acc < OUT_MIN) acc = OUT_MIN;
        return acc[SAMPLE_BITS-1:0];
    endfunction

    function automatic void queue_result(input logic [SAMPLE_BITS-1:0] v, input logic at_end,
                                         input logic too_short);
        t_smoothed res;
        res = {v, at_end, too_short};
        smoothed_due.insert(smoothed_due.size(), res);
    endfunction

    function automatic void smooth_step(input t_stream_word w);
        int                     hw;
        int                     n;
        int                     t;
        logic [SAMPLE_BITS-1:0] v;
        hw = int'(cfg_half_width);
        if (hw < 1) hw = 1;
        if (hw > MAX_HALF_WIDTH) hw = MAX_HALF_WIDTH;
        if (w.op == OP_COEF) begin
            if (w.idx < NTAPS) kern[w.idx] = w.cf;
            return;
        end
        if (seen_cnt == 0) begin
            foreach (win[k]) win[k] = w.smp;
        end else begin
            shift_in(w.smp);
        end
        n = (seen_cnt < SEEN_MAX) ? int'(seen_cnt) + 1 : SEEN_MAX;

        if (cfg_extend) begin
            if (!w.lst) begin
                if (n >= hw + 1) queue_result(fir_value(hw), 1'b0, 1'b0);
                seen_cnt = SEEN_W'(n);
                return;
            end
            // right border: keep replicating the final sample
            for (t = 0; t <= hw; t++) begin
                if (n + t >= hw + 1) queue_result(fir_value(hw), t == hw, 1'b0);
                if (t < hw) shift_in(w.smp);
            end
            seen_cnt = '0;
            return;
        end

        if (n < 2 * hw + 1) begin
            if (w.lst) begin
                queue_result('0, 1'b1, 1'b1);
                seen_cnt = '0;
            end else begin
                seen_cnt = SEEN_W'(n);
            end
            return;
        end
        v = fir_value(hw);
        // left-edge copies only on the first full window, never flagged as last
        if (n == 2 * hw + 1) begin
            repeat (hw + 1) queue_result(v, 1'b0, 1'b0);
        end else begin
            queue_result(v, 1'b0, 1'b0);
        end
        if (w.lst) begin
            for (t = 0; t < hw; t++) queue_result(v, t == hw - 1, 1'b0);
            seen_cnt = '0;
        end else begin
            seen_cnt = SEEN_W'(n);
        end
    endfunction

    // ---------------- driver and monitor ----------------

    always @(negedge i_clk) begin
        if (!i_valid || word_taken) begin
            if (word_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                next_word = word_q.pop_front();
                i_valid     <= 1'b1;
                i_opcode    <= next_word.op;
                i_sample    <= next_word.smp;
                i_tap_index <= next_word.idx;
                i_coef      <= next_word.cf;
                i_last      <= next_word.lst;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        word_taken = 1'b0;
        if (i_rst_n) begin
            if (o_valid === 1'b1 && i_ready) begin
                if (smoothed_due.size() == 0) begin
                    $display("%0t: unexpected result: smoothed %0d last_out %b too_short %b",
                             $time, o_smoothed, o_last_out, o_too_short);
                    mismatches++;
                end else begin
                    due_now = smoothed_due.pop_front();
                    if (o_smoothed !== due_now.value) begin
                        $display("%0t: smoothed mismatch: expected %0d, actual %0d",
                                 $time, $signed(due_now.value), o_smoothed);
                        mismatches++;
                    end
                    if (o_last_out !== due_now.at_end) begin
                        $display("%0t: last_out mismatch: expected %b, actual %b",
                                 $time, due_now.at_end, o_last_out);
                        mismatches++;
                    end
                    if (o_too_short !== due_now.too_short) begin
                        $display("%0t: too_short mismatch: expected %b, actual %b",
                                 $time, due_now.too_short, o_too_short);
                        mismatches++;
                    end
                end
            end
            if (i_valid && o_ready === 1'b1) begin
                word_taken = 1'b1;
                taken_word = {i_opcode, i_sample, i_tap_index, i_coef, i_last};
                smooth_step(taken_word);
            end
            if (i_cfg_valid && o_cfg_ready === 1'b1) begin
                if (i_cfg_index == CFG_HALF_WIDTH) cfg_half_width = i_cfg_data;
                else cfg_extend = i_cfg_data[0];
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ---------------- stimulus ----------------

    function automatic logic [COEF_BITS-1:0] pick_coef();
        if ($urandom_range(3) == 0) return COEF_BITS'($urandom);
        return COEF_BITS'(int'($urandom_range(6000)) - 1500);
    endfunction

    task automatic push_word(input logic op, input logic [SAMPLE_BITS-1:0] smp,
                             input logic [IDX_W-1:0] idx, input logic [COEF_BITS-1:0] cf,
                             input logic lst);
        t_stream_word w;
        w = {op, smp, idx, cf, lst};
        word_q.insert(word_q.size(), w);
        // writes to slots past the kernel are dropped by the block
        if (!(op == OP_COEF && idx >= NTAPS)) queued++;
    endtask

    task automatic push_coef(input int slot, input logic [COEF_BITS-1:0] cf);
        push_word(OP_COEF, SAMPLE_BITS'($urandom), IDX_W'(slot), cf, 1'($urandom));
    endtask

    task automatic push_sample(input logic [SAMPLE_BITS-1:0] s, input logic lst);
        push_word(OP_SAMPLE, s, IDX_W'($urandom), COEF_BITS'($urandom), lst);
    endtask

    task automatic push_signal(input int len, input int hw);
        int k;
        int base;
        bit wild;
        wild = ($urandom_range(2) == 0);
        base = int'($urandom_range(32000)) - 16000;
        for (k = 0; k < len; k++) begin
            if (k > 0 && $urandom_range(11) == 0) push_coef($urandom_range(2 * hw), pick_coef());
            if (wild) push_sample(SAMPLE_BITS'($urandom), k == len - 1);
            else push_sample(SAMPLE_BITS'(base + int'($urandom_range(2000)) - 1000), k == len - 1);
        end
    endtask

    task automatic fill_phase(input int hw, input bit with_long);
        int k;
        int start;
        start = queued;
        for (k = 0; k < 2 * hw + 1; k++) push_coef(k, pick_coef());
        if (with_long) push_signal(40, hw);
        while (queued - start < PHASE_WORDS) begin
            case ($urandom_range(9))
                0: push_coef($urandom_range(31, NTAPS), COEF_BITS'($urandom));
                1: push_coef($urandom_range(NTAPS - 1), pick_coef());
                default: push_signal(($urandom_range(3) == 0) ? $urandom_range(2 * hw, 1)
                                     : $urandom_range(2 * hw + 8, 2 * hw + 1), hw);
            endcase
        end
    endtask

    // block idle: nothing queued, nothing in flight, nothing owed, then a quiet spell
    task automatic settle();
        do @(negedge i_clk);
        while (word_q.size() != 0 || i_valid || smoothed_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk);
        while (o_cfg_ready !== 1'b1);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int p;
        int eff;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: half width 2, borders extended; 5-point quadratic kernel
        push_coef(0, COEF_BITS'(-1404));
        push_coef(1, COEF_BITS'(5617));
        push_coef(2, COEF_BITS'(7958));
        push_coef(3, COEF_BITS'(5617));
        push_coef(4, COEF_BITS'(-1404));
        push_coef(16, 18'h1ffff);
        push_coef(31, 18'h20000);
        push_sample(16'h7fff, 1'b0);
        push_sample(16'h8000, 1'b0);
        push_sample(16'd100, 1'b0);
        push_coef(2, 18'h1ffff);            // tap change in the middle of a signal
        push_sample(16'h7fff, 1'b0);
        push_sample(16'h8000, 1'b1);
        push_sample(SAMPLE_BITS'(-5), 1'b1); // one-sample signal
        settle();

        write_reg(CFG_EXTEND, {3'($urandom), 1'b0});
        push_sample(16'd7, 1'b0);
        push_sample(16'd8, 1'b1);           // shorter than the kernel
        push_sample(16'd1, 1'b0);
        push_sample(16'd2, 1'b0);
        push_sample(16'd3, 1'b0);
        settle();
        // narrower kernel mid-signal, so the left-edge copies never appear
        write_reg(CFG_HALF_WIDTH, 4'd1);
        push_sample(16'd4, 1'b0);
        push_sample(16'd5, 1'b1);
        push_sample(16'd30000, 1'b0);
        push_sample(SAMPLE_BITS'(-30000), 1'b0);
        push_sample(16'd12345, 1'b1);       // exactly one full window
        settle();

        for (p = 0; p < PHASES; p++) begin
            write_reg(CFG_HALF_WIDTH, CFG_DATA_W'(phase_hw[p]));
            write_reg(CFG_EXTEND, {3'($urandom), 1'(phase_ext[p])});
            send_idle_pct = phase_idle[p];
            stall_pct     = phase_stall[p];
            eff = (phase_hw[p] > MAX_HALF_WIDTH) ? MAX_HALF_WIDTH : phase_hw[p];
            fill_phase(eff, phase_hw[p] == 1);
            settle();
        end

        if (mismatches == 0 && smoothed_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
